// File: rtl/ipv4_fragment_reassembly_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define IFRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define IFRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ifrt_pkg.sv
// Package for the IPv4 fragment reassembly tracker: codes, item type, hash step.
// No dependencies.
`timescale 1ns / 1ps

package ifrt_pkg;

  // Widest bucket index over the supported bucket counts.
  localparam int BKT_W = 12;

  localparam logic CMD_FRAGMENT = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  localparam logic [0:0] REG_TIMEOUT = 1'd0;
  localparam logic [0:0] REG_MAX_LEN = 1'd1;

  // Bit positions in the flow marks.
  localparam int MARK_FIRST = 0;
  localparam int MARK_LAST  = 1;
  localparam int MARK_DONE  = 2;

  localparam logic [31:0] HASH_INIT  = 32'hdeadbeef + 32'd12;
  localparam int          HASH_STEPS = 7;
  localparam int          MOD_BITS   = 4;
  localparam int          MOD_CYCLES = 32 / MOD_BITS;

  typedef enum logic [2:0] {
    ST_CACHED    = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_OVERSIZE  = 3'd4,
    ST_TICK_DONE = 3'd5
  } status_t;

  typedef struct packed {
    logic             command;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      datagram_id;
    logic [15:0]      byte_offset;
    logic [15:0]      payload_len;
    logic             more_fragments;
    logic [5:0]       header_len;
    logic [BKT_W-1:0] bucket;
  } item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } hash_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_TICK_RD, B_TICK_CHK, B_WAY_RD, B_WAY_CHK, B_DECIDE, B_PLACE,
    B_SCAN_RD, B_SCAN_CHK, B_CHECK, B_SHIFT, B_SHIFT_WR, B_UPDATE, B_FINISH,
    B_WRITE_REC, B_RESULT
  } back_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // One mixing step of the three-word final mix.
  function automatic hash_t hash_step(input hash_t h, input logic [2:0] step);
    hash_t r;
    r = h;
    case (step)
      3'd0: r.c = (h.c ^ h.b) - rotl(h.b, 14);
      3'd1: r.a = (h.a ^ h.c) - rotl(h.c, 11);
      3'd2: r.b = (h.b ^ h.a) - rotl(h.a, 25);
      3'd3: r.c = (h.c ^ h.b) - rotl(h.b, 16);
      3'd4: r.a = (h.a ^ h.c) - rotl(h.c, 4);
      3'd5: r.b = (h.b ^ h.a) - rotl(h.a, 14);
      3'd6: r.c = (h.c ^ h.b) - rotl(h.b, 24);
      default: r = h;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ifrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ifrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ifrt_front.sv
// Front part of the tracker: accepts words, hashes the flow key, picks the bucket.
// Depends on ifrt_pkg.
`timescale 1ns / 1ps

module ifrt_front #(
  parameter int BUCKETS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [31:0]   src_addr,
  input  logic [31:0]   dst_addr,
  input  logic [15:0]   datagram_id,
  input  logic [15:0]   byte_offset,
  input  logic [15:0]   payload_len,
  input  logic          more_fragments,
  input  logic [5:0]    header_len,
  output logic          push,
  output ifrt_pkg::item_t push_item,
  input  logic          full
);
  import ifrt_pkg::*;

  localparam int RW = $clog2(BUCKETS) + 2;

  front_state_t fstate, fstate_next;
  item_t        item;
  hash_t        hash;
  logic [2:0]   step;
  logic [2:0]   mod_cnt;
  logic [RW-1:0] rem, rem_next;
  logic [RW-1:0] r_work;
  logic [31:0]  d_work;

  // Restoring remainder of hash.c by BUCKETS, taking MOD_BITS dividend bits per step.
  always_comb begin
    r_work = rem;
    d_work = hash.c;
    for (int j = 0; j < MOD_BITS; j++) begin
      r_work = {r_work[RW-2:0], d_work[31]};
      d_work = d_work << 1;
      if (r_work >= RW'(BUCKETS)) begin
        r_work = r_work - RW'(BUCKETS);
      end
    end
    rem_next = r_work;
  end

  always_comb begin
    fstate_next = fstate;
    unique case (fstate)
      F_IDLE: begin
        if (in_valid) begin
          fstate_next = (command == CMD_TICK) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (step == 3'(HASH_STEPS - 1)) fstate_next = F_MOD;
      end
      F_MOD: begin
        if (mod_cnt == 3'(MOD_CYCLES - 1)) fstate_next = F_PUSH;
      end
      F_PUSH: begin
        if (!full) fstate_next = F_IDLE;
      end
      default: fstate_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (fstate == F_IDLE);
    push      = (fstate == F_PUSH) && !full;
    push_item = item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_ff @(posedge clk) begin
    case (fstate)
      F_IDLE: begin
        if (in_valid) begin
          item.command        <= command;
          item.src_addr       <= src_addr;
          item.dst_addr       <= dst_addr;
          item.datagram_id    <= datagram_id;
          item.byte_offset    <= byte_offset;
          item.payload_len    <= payload_len;
          item.more_fragments <= more_fragments;
          item.header_len     <= header_len;
          item.bucket         <= '0;
          hash.a <= src_addr + HASH_INIT;
          hash.b <= dst_addr + HASH_INIT;
          hash.c <= {16'd0, datagram_id} + HASH_INIT;
          step   <= '0;
        end
      end
      F_HASH: begin
        hash    <= hash_step(hash, step);
        step    <= step + 3'd1;
        rem     <= '0;
        mod_cnt <= '0;
      end
      F_MOD: begin
        rem     <= rem_next;
        hash.c  <= hash.c << MOD_BITS;
        mod_cnt <= mod_cnt + 3'd1;
        if (mod_cnt == 3'(MOD_CYCLES - 1)) begin
          item.bucket <= BKT_W'(rem_next);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/ifrt_queue.sv
// Two-entry queue of classified words between the front and back parts.
// Depends on ifrt_pkg.
`timescale 1ns / 1ps

module ifrt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ifrt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output ifrt_pkg::item_t pop_item,
  output logic            empty
);
  import ifrt_pkg::*;

  item_t      slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ifrt_engine.sv
// Back part of the tracker: flow table, interval lists, aging and result register.
// Depends on ifrt_pkg, ifrt_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "ipv4_fragment_reassembly_tracker_macros.svh"

module ifrt_engine #(
  parameter int BUCKETS   = 64,
  parameter int WAYS      = 4,
  parameter int MAX_FRAGS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ifrt_pkg::item_t q_item,
  output logic            q_pop,
  input  logic [15:0]     timeout_ticks,
  input  logic [15:0]     max_datagram_len,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      status,
  output logic [7:0]      flow_slot,
  output logic [15:0]     datagram_len,
  output logic [4:0]      fragment_count,
  output logic [8:0]      aged_count
);
  import ifrt_pkg::*;

  localparam int SLOTS  = BUCKETS * WAYS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAGS + 1);
  localparam int IDX_W  = $clog2(SLOTS * MAX_FRAGS);
  localparam int AGE_W  = SLOT_W + 1;

  typedef struct packed {
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [15:0]      ident;
    logic [31:0]      stamp;
    logic [16:0]      total;
    logic [16:0]      rcvd;
    logic [2:0]       marks;
    logic [CNT_W-1:0] cnt;
    logic [5:0]       hlen;
  } rec_t;

  back_state_t state, state_next;

  logic [31:0]      time_now;
  logic [SLOTS-1:0] flow_valid;
  item_t            item;

  logic [SLOT_W-1:0] tick_k;
  logic [WAY_W-1:0]  way;
  logic [SLOT_W-1:0] way_slot;
  logic              found_ok, free_ok;
  logic [SLOT_W-1:0] found_slot, free_slot, cur_slot;

  logic [16:0]      f_total, f_rcvd;
  logic [2:0]       f_marks;
  logic [CNT_W-1:0] f_cnt;
  logic [5:0]       f_hlen;

  logic [CNT_W-1:0] scan_k, pos, shift_i;
  logic             pos_ok, prev_ok;
  logic [15:0]      prev_start, prev_len, next_start;

  status_t          res_status;
  logic [15:0]      res_dlen;
  logic [4:0]       res_cnt;
  logic [AGE_W-1:0] res_aged;

  logic [16:0] frag_end;
  logic        drop_early, drop_overlap, aged_now, is_done;
  logic [17:0] dgram_total;

  logic              rec_rd_en, rec_wr_en;
  logic [SLOT_W-1:0] rec_rd_addr;
  rec_t              rec_rd_data, rec_wr_data;
  logic              iv_rd_en, iv_wr_en;
  logic [IDX_W-1:0]  iv_rd_addr, iv_wr_addr;
  logic [31:0]       iv_rd_data, iv_wr_data;
  logic [15:0]       iv_start, iv_len;

  function automatic logic [IDX_W-1:0] iv_addr(input logic [SLOT_W-1:0] s,
                                               input logic [CNT_W-1:0] k);
    return IDX_W'(32'(s) * MAX_FRAGS + 32'(k));
  endfunction

  ifrt_ram #(.WIDTH($bits(rec_t)), .DEPTH(SLOTS)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_wr_en),
    .wr_addr (cur_slot),
    .wr_data (rec_wr_data),
    .rd_en   (rec_rd_en),
    .rd_addr (rec_rd_addr),
    .rd_data (rec_rd_data)
  );

  ifrt_ram #(.WIDTH(32), .DEPTH(SLOTS * MAX_FRAGS)) u_iv_ram (
    .clk     (clk),
    .wr_en   (iv_wr_en),
    .wr_addr (iv_wr_addr),
    .wr_data (iv_wr_data),
    .rd_en   (iv_rd_en),
    .rd_addr (iv_rd_addr),
    .rd_data (iv_rd_data)
  );

  assign iv_start = iv_rd_data[31:16];
  assign iv_len   = iv_rd_data[15:0];

  // Classification of the current fragment against the flow state.
  always_comb begin
    way_slot = SLOT_W'(32'(item.bucket) * WAYS + 32'(way));
    frag_end = {1'b0, item.byte_offset} + {1'b0, item.payload_len};
    is_done  = f_marks[MARK_DONE];
    if (!item.more_fragments) begin
      drop_early = is_done || (frag_end < f_total) || f_marks[MARK_LAST];
    end else begin
      drop_early = is_done || ((frag_end > f_total) && f_marks[MARK_LAST]);
    end
    drop_overlap = (prev_ok && (({1'b0, prev_start} + {1'b0, prev_len}) >
                                {1'b0, item.byte_offset}))
                || (pos_ok && ({1'b0, next_start} < frag_end))
                || (f_cnt >= CNT_W'(MAX_FRAGS));
    aged_now = flow_valid[tick_k]
            && ((time_now - rec_rd_data.stamp) > {16'd0, timeout_ticks});
    dgram_total = 18'(f_hlen) + 18'(f_total);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) state_next = (q_item.command == CMD_TICK) ? B_TICK_RD : B_WAY_RD;
      end
      B_TICK_RD:  state_next = B_TICK_CHK;
      B_TICK_CHK: state_next = (tick_k == SLOT_W'(SLOTS - 1)) ? B_RESULT : B_TICK_RD;
      B_WAY_RD:   state_next = B_WAY_CHK;
      B_WAY_CHK:  state_next = (way == WAY_W'(WAYS - 1)) ? B_DECIDE : B_WAY_RD;
      B_DECIDE:   state_next = (!found_ok && !free_ok) ? B_RESULT : B_PLACE;
      B_PLACE: begin
        if (drop_early)          state_next = B_WRITE_REC;
        else if (f_cnt == '0)    state_next = B_CHECK;
        else                     state_next = B_SCAN_RD;
      end
      B_SCAN_RD: state_next = B_SCAN_CHK;
      B_SCAN_CHK: begin
        if ((iv_start >= item.byte_offset) || (scan_k == f_cnt - CNT_W'(1))) begin
          state_next = B_CHECK;
        end else begin
          state_next = B_SCAN_RD;
        end
      end
      B_CHECK:     state_next = drop_overlap ? B_WRITE_REC : B_SHIFT;
      B_SHIFT:     state_next = (shift_i > pos) ? B_SHIFT_WR : B_UPDATE;
      B_SHIFT_WR:  state_next = B_SHIFT;
      B_UPDATE:    state_next = B_FINISH;
      B_FINISH:    state_next = B_WRITE_REC;
      B_WRITE_REC: state_next = B_RESULT;
      B_RESULT: begin
        if (!out_valid || out_ready) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state == B_IDLE) && !q_empty;
    rec_rd_en   = (state == B_TICK_RD) || (state == B_WAY_RD);
    rec_rd_addr = (state == B_TICK_RD) ? tick_k : way_slot;
    rec_wr_en   = (state == B_WRITE_REC);
    rec_wr_data = '{src: item.src_addr, dst: item.dst_addr, ident: item.datagram_id,
                    stamp: time_now, total: f_total, rcvd: f_rcvd, marks: f_marks,
                    cnt: f_cnt, hlen: f_hlen};
    iv_rd_en    = (state == B_SCAN_RD) || ((state == B_SHIFT) && (shift_i > pos));
    iv_rd_addr  = (state == B_SCAN_RD) ? iv_addr(cur_slot, scan_k)
                                       : iv_addr(cur_slot, shift_i - CNT_W'(1));
    iv_wr_en    = (state == B_SHIFT_WR) || ((state == B_SHIFT) && !(shift_i > pos));
    iv_wr_addr  = (state == B_SHIFT_WR) ? iv_addr(cur_slot, shift_i)
                                        : iv_addr(cur_slot, pos);
    iv_wr_data  = (state == B_SHIFT_WR) ? iv_rd_data
                                        : {item.byte_offset, item.payload_len};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      time_now   <= '0;
      flow_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE && !q_empty && q_item.command == CMD_TICK) begin
        time_now <= time_now + 32'd1;
      end
      if (state == B_TICK_CHK && aged_now) begin
        flow_valid[tick_k] <= 1'b0;
      end
      if (state == B_DECIDE && !found_ok && free_ok) begin
        flow_valid[free_slot] <= 1'b1;
      end
      if (state == B_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item       <= q_item;
        tick_k     <= '0;
        way        <= '0;
        found_ok   <= 1'b0;
        free_ok    <= 1'b0;
        cur_slot   <= '0;
        res_dlen   <= '0;
        res_cnt    <= '0;
        res_aged   <= '0;
        res_status <= ST_TICK_DONE;
      end
      B_TICK_CHK: begin
        if (aged_now) res_aged <= res_aged + AGE_W'(1);
        tick_k <= tick_k + SLOT_W'(1);
      end
      B_WAY_CHK: begin
        if (flow_valid[way_slot]) begin
          if (!found_ok && rec_rd_data.src == item.src_addr
              && rec_rd_data.dst == item.dst_addr
              && rec_rd_data.ident == item.datagram_id) begin
            found_ok   <= 1'b1;
            found_slot <= way_slot;
            f_total    <= rec_rd_data.total;
            f_rcvd     <= rec_rd_data.rcvd;
            f_marks    <= rec_rd_data.marks;
            f_cnt      <= rec_rd_data.cnt;
            f_hlen     <= rec_rd_data.hlen;
          end
        end else if (!free_ok) begin
          free_ok   <= 1'b1;
          free_slot <= way_slot;
        end
        way <= way + WAY_W'(1);
      end
      B_DECIDE: begin
        if (found_ok) begin
          cur_slot <= found_slot;
        end else if (free_ok) begin
          cur_slot <= free_slot;
          f_total  <= '0;
          f_rcvd   <= '0;
          f_marks  <= '0;
          f_cnt    <= '0;
          f_hlen   <= '0;
        end else begin
          res_status <= ST_NO_ROOM;
        end
      end
      B_PLACE: begin
        if (drop_early) begin
          res_status <= ST_DROPPED;
        end else if (!item.more_fragments) begin
          f_marks[MARK_LAST] <= 1'b1;
          f_total            <= frag_end;
        end else if (frag_end > f_total) begin
          f_total <= frag_end;
        end
        scan_k  <= '0;
        pos     <= f_cnt;
        pos_ok  <= 1'b0;
        prev_ok <= 1'b0;
      end
      B_SCAN_CHK: begin
        if (iv_start >= item.byte_offset) begin
          pos_ok     <= 1'b1;
          pos        <= scan_k;
          next_start <= iv_start;
        end else begin
          prev_ok    <= 1'b1;
          prev_start <= iv_start;
          prev_len   <= iv_len;
        end
        scan_k <= scan_k + CNT_W'(1);
      end
      B_CHECK: begin
        if (drop_overlap) res_status <= ST_DROPPED;
        shift_i <= f_cnt;
      end
      B_SHIFT_WR: begin
        shift_i <= shift_i - CNT_W'(1);
      end
      B_UPDATE: begin
        f_cnt  <= f_cnt + CNT_W'(1);
        f_rcvd <= f_rcvd + {1'b0, item.payload_len};
        if (item.byte_offset == 16'd0) begin
          f_marks[MARK_FIRST] <= 1'b1;
          f_hlen              <= item.header_len;
        end
      end
      B_FINISH: begin
        if (f_marks == 3'b011 && f_rcvd == f_total) begin
          if (dgram_total > 18'(max_datagram_len)) begin
            res_status <= ST_OVERSIZE;
          end else begin
            res_status        <= ST_COMPLETE;
            res_dlen          <= dgram_total[15:0];
            res_cnt           <= 5'(f_cnt);
            f_marks[MARK_DONE] <= 1'b1;
            f_cnt             <= '0;
          end
        end else begin
          res_status <= ST_CACHED;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == B_RESULT && (!out_valid || out_ready)) begin
      status         <= res_status;
      flow_slot      <= 8'(cur_slot);
      datagram_len   <= res_dlen;
      fragment_count <= res_cnt;
      aged_count     <= 9'(res_aged);
    end
  end

  `IFRT_ASSERT_NOW(a_tick_fields, out_valid && status == ST_TICK_DONE,
    flow_slot == 8'd0 && datagram_len == 16'd0 && fragment_count == 5'd0,
    "tick result carries flow fields")
  `IFRT_ASSERT_NOW(a_aged_only_tick, out_valid && status != ST_TICK_DONE,
    aged_count == 9'd0, "aged count on a fragment result")
  `IFRT_ASSERT_NOW(a_shift_range, state == B_SHIFT_WR,
    shift_i > pos && shift_i < CNT_W'(MAX_FRAGS), "interval shift out of range")
  `IFRT_ASSERT_NEXT(a_no_room, state == B_DECIDE && !found_ok && !free_ok,
    state == B_RESULT && res_status == ST_NO_ROOM, "full bucket not reported")

endmodule

// File: rtl/ipv4_fragment_reassembly_tracker.sv
// Top level of the IPv4 fragment reassembly tracker: configuration and block wiring.
// Depends on ifrt_pkg, ifrt_front, ifrt_queue and ifrt_engine.
`timescale 1ns / 1ps

// The tracker takes one word per fragment or time tick and returns one result word
// for each, in order. The front part hashes a fragment's key and reckons its bucket
// remainder; overlapped with that, the back part probes each way of the bucket, scans
// and moves intervals and writes the flow record, one access at a time through the
// single read port of the flow record and interval memories. A tick skips the hash
// and walks every flow slot. A two-word queue sits between hashing and the table work,
// and the result register lets the next word start while a result waits. Write
// timeout_ticks and max_datagram_len only while the block is idle. The flow table
// needs no clearing after reset: its valid bits clear at once.
module ipv4_fragment_reassembly_tracker #(
  parameter int BUCKETS   = 64,
  parameter int WAYS      = 4,
  parameter int MAX_FRAGS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] datagram_id,
  input  logic [15:0] byte_offset,
  input  logic [15:0] payload_len,
  input  logic        more_fragments,
  input  logic [5:0]  header_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  flow_slot,
  output logic [15:0] datagram_len,
  output logic [4:0]  fragment_count,
  output logic [8:0]  aged_count
);
  import ifrt_pkg::*;

  logic [15:0] timeout_ticks;
  logic [15:0] max_datagram_len;

  item_t push_item, pop_item;
  logic  push, full, pop, empty;

  // Configuration registers feed the back part directly and also affect a word already in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks    <= 16'd30;
      max_datagram_len <= 16'hffff;
    end else if (cfg_write) begin
      if (cfg_index == REG_TIMEOUT) timeout_ticks <= cfg_data;
      if (cfg_index == REG_MAX_LEN) max_datagram_len <= cfg_data;
    end
  end

  ifrt_front #(.BUCKETS(BUCKETS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .src_addr       (src_addr),
    .dst_addr       (dst_addr),
    .datagram_id    (datagram_id),
    .byte_offset    (byte_offset),
    .payload_len    (payload_len),
    .more_fragments (more_fragments),
    .header_len     (header_len),
    .push           (push),
    .push_item      (push_item),
    .full           (full)
  );

  ifrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  ifrt_engine #(.BUCKETS(BUCKETS), .WAYS(WAYS), .MAX_FRAGS(MAX_FRAGS)) u_engine (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (empty),
    .q_item           (pop_item),
    .q_pop            (pop),
    .timeout_ticks    (timeout_ticks),
    .max_datagram_len (max_datagram_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .flow_slot        (flow_slot),
    .datagram_len     (datagram_len),
    .fragment_count   (fragment_count),
    .aged_count       (aged_count)
  );

endmodule
